/* hw/rtl/cbpe_pkg.sv */
`default_nettype none

package cbpe_pkg;

   // Field widths.
   localparam int COORD_BITS    = 16;
   localparam int FRACTION_BITS = 16;
   localparam int INDEX_BITS    = 16;

   localparam logic [INDEX_BITS-1:0] POINT_COUNT_RESET = INDEX_BITS'(1000);

   // Divider: quotient bits resolved per pipeline stage.
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = (FRACTION_BITS + DIV_BITS - 1) / DIV_BITS;

   // Evaluation stages, the last one being the output register.
   localparam int EVAL_STAGES = 6;
   localparam int PIPE_STAGES = 1 + DIV_STAGES + EVAL_STAGES;

   localparam int NUM_AXES = 2;
   localparam int AXIS_X   = 0;
   localparam int AXIS_Y   = 1;

   // Internal widths of the exact Horner evaluation.
   localparam int COEF_BITS = COORD_BITS + 4;
   localparam int T_BITS    = FRACTION_BITS + 1;
   localparam int A_BITS    = COORD_BITS + FRACTION_BITS + 5;
   localparam int AQ_BITS   = A_BITS - FRACTION_BITS;
   localparam int AT_BITS   = AQ_BITS + T_BITS;
   localparam int PROD_BITS = 2 * FRACTION_BITS + 1;
   localparam int B_BITS    = AT_BITS + 1;
   localparam int BQ_BITS   = B_BITS - FRACTION_BITS;
   localparam int BQT_BITS  = BQ_BITS + T_BITS;
   localparam int G_BITS    = PROD_BITS + 1;
   localparam int D_BITS    = BQT_BITS + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [INDEX_BITS-1:0] index_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic        [T_BITS-1:0]     tval_type;
   typedef logic signed [T_BITS:0]       tsig_type;
   typedef logic signed [A_BITS-1:0]     a_type;
   typedef logic signed [AQ_BITS-1:0]    aq_type;
   typedef logic signed [AT_BITS-1:0]    at_type;
   typedef logic        [PROD_BITS-1:0]  prod_type;
   typedef logic signed [B_BITS-1:0]     b_type;
   typedef logic signed [BQ_BITS-1:0]    bq_type;
   typedef logic signed [BQT_BITS-1:0]   bqt_type;
   typedef logic        [G_BITS-1:0]     g_type;
   typedef logic signed [D_BITS-1:0]     d_type;

   // Power-basis coefficients of one axis.
   typedef struct packed {
      coef_type c0;
      coef_type c1;
      coef_type c2;
      coef_type c3;
   } coef_set_type;

   localparam coef_type COEF_THREE = coef_type'(3);
   localparam coef_type COEF_SIX   = coef_type'(6);

   // One half in the units of the final rounding shift.
   localparam d_type ROUND_HALF = d_type'(1) <<< (FRACTION_BITS - 1);

endpackage

`default_nettype wire

/* hw/rtl/cbpe_if.sv */
`default_nettype none

// Request word: four control points and the sample index.
interface cbpe_req_if;
   logic                valid;
   logic                ready;
   cbpe_pkg::coord_type p0_x;
   cbpe_pkg::coord_type p0_y;
   cbpe_pkg::coord_type p1_x;
   cbpe_pkg::coord_type p1_y;
   cbpe_pkg::coord_type p2_x;
   cbpe_pkg::coord_type p2_y;
   cbpe_pkg::coord_type p3_x;
   cbpe_pkg::coord_type p3_y;
   cbpe_pkg::index_type sample_index;

   modport source (
      output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, sample_index,
      input  ready
   );
   modport sink (
      input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, sample_index,
      output ready
   );
endinterface

// Response word: the rounded curve point and the clamp flag.
interface cbpe_rsp_if;
   logic                valid;
   logic                ready;
   cbpe_pkg::coord_type pixel_x;
   cbpe_pkg::coord_type pixel_y;
   logic                index_clamped;

   modport source (
      output valid, pixel_x, pixel_y, index_clamped,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, index_clamped,
      output ready
   );
endinterface

`default_nettype wire

/* hw/rtl/cubic_bezier_point_evaluator.sv */
// Cubic Bezier point evaluator.
// A request word on req_chan carries the control points P0..P3 and a sample
// index i; the response word on rsp_chan is the curve point at
// t = i / point_count, rounded half up to integer coordinates. An index above
// point_count is clamped to the end point and flagged in index_clamped.
// The user writes point_count through csr_wr_en / csr_wr_data only while no
// word is in flight (not enforced by the block); a value of zero acts as one.
// The pipeline has 1 + ceil(FRACTION_BITS / 2) + 6 register stages, 15 at 16
// fraction bits: one entry stage, the restoring divider that resolves two
// quotient bits per stage, and six Horner evaluation stages. The pipeline
// takes one word per cycle while the receiver keeps taking words; every stage
// holds one word and moves on its own enable.
// When the receiver stalls, the output register holds its word and empty
// stages upstream keep filling, so req_chan.ready falls only once every
// stage is occupied. Nothing is dropped or repeated.
// Synchronous reset empties the pipeline and sets point_count to 1000.
`default_nettype none

module cubic_bezier_point_evaluator (
   input  wire logic                clock,
   input  wire logic                reset,
   cbpe_req_if.sink                 req_chan,
   cbpe_rsp_if.source               rsp_chan,
   input  wire logic                csr_wr_en,
   input  wire cbpe_pkg::index_type csr_wr_data
);

   localparam int FB    = cbpe_pkg::FRACTION_BITS;
   localparam int IB    = cbpe_pkg::INDEX_BITS;
   localparam int CB    = cbpe_pkg::COORD_BITS;
   localparam int DS    = cbpe_pkg::DIV_STAGES;
   localparam int PS    = cbpe_pkg::PIPE_STAGES;
   localparam int NA    = cbpe_pkg::NUM_AXES;
   localparam int ST_E1 = DS + 1;
   localparam int ST_E2 = DS + 2;
   localparam int ST_E3 = DS + 3;
   localparam int ST_E4 = DS + 4;
   localparam int ST_E5 = DS + 5;
   localparam int ST_E6 = DS + 6;

   // Configuration register.
   cbpe_pkg::index_type point_count_ff;
   cbpe_pkg::index_type n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= cbpe_pkg::POINT_COUNT_RESET;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   assign n_eff = (point_count_ff == '0) ? cbpe_pkg::index_type'(1) : point_count_ff;

   // Per-stage valid bits and enables: a stage loads when it is empty or
   // when the stage after it loads too.
   logic [PS-1:0] valid_ff;
   logic [PS-1:0] stage_en;

   always_comb begin
      stage_en[PS-1] = !valid_ff[PS-1] || rsp_chan.ready;
      for (int k = PS - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < PS; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_chan.ready = stage_en[0];

   // Entry stage: control points per axis and the basis matrix product.
   cbpe_pkg::coord_type    in_pt [NA][4];
   cbpe_pkg::coef_set_type coef_in [NA];

   assign in_pt[cbpe_pkg::AXIS_X][0] = req_chan.p0_x;
   assign in_pt[cbpe_pkg::AXIS_X][1] = req_chan.p1_x;
   assign in_pt[cbpe_pkg::AXIS_X][2] = req_chan.p2_x;
   assign in_pt[cbpe_pkg::AXIS_X][3] = req_chan.p3_x;
   assign in_pt[cbpe_pkg::AXIS_Y][0] = req_chan.p0_y;
   assign in_pt[cbpe_pkg::AXIS_Y][1] = req_chan.p1_y;
   assign in_pt[cbpe_pkg::AXIS_Y][2] = req_chan.p2_y;
   assign in_pt[cbpe_pkg::AXIS_Y][3] = req_chan.p3_y;

   always_comb begin
      cbpe_pkg::coef_type e0;
      cbpe_pkg::coef_type e1;
      cbpe_pkg::coef_type e2;
      cbpe_pkg::coef_type e3;
      for (int ax = 0; ax < NA; ax++) begin
         e0 = cbpe_pkg::coef_type'(in_pt[ax][0]);
         e1 = cbpe_pkg::coef_type'(in_pt[ax][1]);
         e2 = cbpe_pkg::coef_type'(in_pt[ax][2]);
         e3 = cbpe_pkg::coef_type'(in_pt[ax][3]);
         coef_in[ax].c0 = e3 - e0 + cbpe_pkg::COEF_THREE * (e1 - e2);
         coef_in[ax].c1 = cbpe_pkg::COEF_THREE * (e0 + e2) - cbpe_pkg::COEF_SIX * e1;
         coef_in[ax].c2 = cbpe_pkg::COEF_THREE * (e1 - e0);
         coef_in[ax].c3 = e0;
      end
   end

   // Divider: t = floor(i * 2^FB / n). The entry stage clamps i and settles
   // the integer bit; each later stage resolves DIV_BITS fraction bits while
   // the integer bit stays in place.
   cbpe_pkg::index_type    div_rem_ff [DS+1];
   cbpe_pkg::index_type    div_rem_in [DS+1];
   cbpe_pkg::tval_type     div_q_ff   [DS+1];
   cbpe_pkg::tval_type     div_q_in   [DS+1];
   logic                   clamp_ff   [DS+1];
   logic                   clamp_in;
   cbpe_pkg::coef_set_type coef_ff    [DS+1][NA];

   always_comb begin
      cbpe_pkg::index_type idx;
      logic                full;
      logic [IB:0]         dbl;
      cbpe_pkg::index_type r;
      cbpe_pkg::tval_type  q;
      clamp_in      = req_chan.sample_index > n_eff;
      idx           = clamp_in ? n_eff : req_chan.sample_index;
      full          = (idx == n_eff);
      div_rem_in[0] = full ? '0 : idx;
      div_q_in[0]   = cbpe_pkg::tval_type'(full) << FB;
      dbl           = '0;
      for (int s = 1; s <= DS; s++) begin
         r = div_rem_ff[s-1];
         q = div_q_ff[s-1];
         for (int j = 0; j < cbpe_pkg::DIV_BITS; j++) begin
            if ((s - 1) * cbpe_pkg::DIV_BITS + j < FB) begin
               dbl = {r, 1'b0};
               if (dbl >= {1'b0, n_eff}) begin
                  dbl = dbl - {1'b0, n_eff};
                  q   = {q[FB], q[FB-2:0], 1'b1};
               end else begin
                  q   = {q[FB], q[FB-2:0], 1'b0};
               end
               r = dbl[IB-1:0];
            end
         end
         div_rem_in[s] = r;
         div_q_in[s]   = q;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         div_rem_ff[0] <= div_rem_in[0];
         div_q_ff[0]   <= div_q_in[0];
         clamp_ff[0]   <= clamp_in;
         coef_ff[0]    <= coef_in;
      end
      for (int s = 1; s <= DS; s++) begin
         if (stage_en[s]) begin
            div_rem_ff[s] <= div_rem_in[s];
            div_q_ff[s]   <= div_q_in[s];
            clamp_ff[s]   <= clamp_ff[s-1];
            coef_ff[s]    <= coef_ff[s-1];
         end
      end
   end

   // Horner evaluation, split so every multiply sees a narrow operand:
   //   a  = c0 t + c1 s, b1 = floor(a/s) t + floor(frac(a) t / s) + c2 s,
   //   d  = floor(b1/s) t + c3 s + s/2 + floor(g/s), result = floor(d/s).
   cbpe_pkg::tval_type  t_div;
   cbpe_pkg::tsig_type  t_div_s;
   cbpe_pkg::tval_type  t_ff [3];
   cbpe_pkg::tsig_type  t_s  [3];
   logic                clamp_e_ff [cbpe_pkg::EVAL_STAGES];

   cbpe_pkg::coef_type  c2_ff  [2][NA];
   cbpe_pkg::coef_type  c3_ff  [4][NA];

   cbpe_pkg::a_type     a_in   [NA];
   cbpe_pkg::a_type     a_ff   [NA];
   cbpe_pkg::at_type    at_in  [NA];
   cbpe_pkg::at_type    at_ff  [NA];
   cbpe_pkg::prod_type  art_in [NA];
   cbpe_pkg::prod_type  art_ff [NA];
   cbpe_pkg::b_type     b1_in  [NA];
   cbpe_pkg::b_type     b1_ff  [NA];
   logic [FB-1:0]       br_in  [NA];
   logic [FB-1:0]       br_ff  [NA];
   cbpe_pkg::bqt_type   bqt_in [NA];
   cbpe_pkg::bqt_type   bqt_ff [NA];
   cbpe_pkg::prod_type  bbt_in [NA];
   cbpe_pkg::prod_type  bbt_ff [NA];
   cbpe_pkg::prod_type  brt_in [NA];
   cbpe_pkg::prod_type  brt_ff [NA];
   cbpe_pkg::g_type     g_in   [NA];
   cbpe_pkg::g_type     g_ff   [NA];
   cbpe_pkg::d_type     dp_in  [NA];
   cbpe_pkg::d_type     dp_ff  [NA];
   cbpe_pkg::d_type     d_sum  [NA];
   cbpe_pkg::coord_type pixel_in [NA];
   cbpe_pkg::coord_type pixel_ff [NA];

   assign t_div   = div_q_ff[DS];
   assign t_div_s = cbpe_pkg::tsig_type'(t_div);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t_s[k] = cbpe_pkg::tsig_type'(t_ff[k]);
      end
   end

   always_comb begin
      cbpe_pkg::aq_type aq;
      logic [FB-1:0]    ar;
      logic [FB:0]      q1;
      cbpe_pkg::bq_type bq;
      logic [FB-1:0]    bb;
      for (int ax = 0; ax < NA; ax++) begin
         // First stage: a = c0 t + c1 s.
         a_in[ax] = cbpe_pkg::a_type'(coef_ff[DS][ax].c0) * cbpe_pkg::a_type'(t_div_s)
                  + (cbpe_pkg::a_type'(coef_ff[DS][ax].c1) <<< FB);
         // Second stage: split a into whole and fraction parts, scale both by t.
         aq         = $signed(a_ff[ax][cbpe_pkg::A_BITS-1:FB]);
         ar         = a_ff[ax][FB-1:0];
         at_in[ax]  = cbpe_pkg::at_type'(aq) * cbpe_pkg::at_type'(t_s[0]);
         art_in[ax] = cbpe_pkg::prod_type'(ar) * cbpe_pkg::prod_type'(t_ff[0]);
         // Third stage: b1 collects the whole parts and adds c2 s.
         q1        = art_ff[ax][cbpe_pkg::PROD_BITS-1:FB];
         br_in[ax] = art_ff[ax][FB-1:0];
         b1_in[ax] = cbpe_pkg::b_type'(at_ff[ax]) + cbpe_pkg::b_type'(q1)
                   + (cbpe_pkg::b_type'(c2_ff[1][ax]) <<< FB);
         // Fourth stage: split b1 and scale every part by t once more.
         bq         = $signed(b1_ff[ax][cbpe_pkg::B_BITS-1:FB]);
         bb         = b1_ff[ax][FB-1:0];
         bqt_in[ax] = cbpe_pkg::bqt_type'(bq) * cbpe_pkg::bqt_type'(t_s[2]);
         bbt_in[ax] = cbpe_pkg::prod_type'(bb) * cbpe_pkg::prod_type'(t_ff[2]);
         brt_in[ax] = cbpe_pkg::prod_type'(br_ff[ax]) * cbpe_pkg::prod_type'(t_ff[2]);
         // Fifth stage: fraction carry g and the rounded whole part.
         g_in[ax]  = cbpe_pkg::g_type'(bbt_ff[ax])
                   + cbpe_pkg::g_type'(brt_ff[ax][cbpe_pkg::PROD_BITS-1:FB]);
         dp_in[ax] = cbpe_pkg::d_type'(bqt_ff[ax]) + (cbpe_pkg::d_type'(c3_ff[3][ax]) <<< FB)
                   + cbpe_pkg::ROUND_HALF;
         // Last stage: fold in the carry and drop the fraction.
         d_sum[ax]    = dp_ff[ax] + cbpe_pkg::d_type'(g_ff[ax][cbpe_pkg::G_BITS-1:FB]);
         pixel_in[ax] = $signed(d_sum[ax][FB+CB-1:FB]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_E1]) begin
         t_ff[0]       <= t_div;
         clamp_e_ff[0] <= clamp_ff[DS];
         for (int ax = 0; ax < NA; ax++) begin
            a_ff[ax]     <= a_in[ax];
            c2_ff[0][ax] <= coef_ff[DS][ax].c2;
            c3_ff[0][ax] <= coef_ff[DS][ax].c3;
         end
      end
      if (stage_en[ST_E2]) begin
         t_ff[1]       <= t_ff[0];
         clamp_e_ff[1] <= clamp_e_ff[0];
         for (int ax = 0; ax < NA; ax++) begin
            at_ff[ax]    <= at_in[ax];
            art_ff[ax]   <= art_in[ax];
            c2_ff[1][ax] <= c2_ff[0][ax];
            c3_ff[1][ax] <= c3_ff[0][ax];
         end
      end
      if (stage_en[ST_E3]) begin
         t_ff[2]       <= t_ff[1];
         clamp_e_ff[2] <= clamp_e_ff[1];
         for (int ax = 0; ax < NA; ax++) begin
            b1_ff[ax]    <= b1_in[ax];
            br_ff[ax]    <= br_in[ax];
            c3_ff[2][ax] <= c3_ff[1][ax];
         end
      end
      if (stage_en[ST_E4]) begin
         clamp_e_ff[3] <= clamp_e_ff[2];
         for (int ax = 0; ax < NA; ax++) begin
            bqt_ff[ax]   <= bqt_in[ax];
            bbt_ff[ax]   <= bbt_in[ax];
            brt_ff[ax]   <= brt_in[ax];
            c3_ff[3][ax] <= c3_ff[2][ax];
         end
      end
      if (stage_en[ST_E5]) begin
         clamp_e_ff[4] <= clamp_e_ff[3];
         for (int ax = 0; ax < NA; ax++) begin
            g_ff[ax]  <= g_in[ax];
            dp_ff[ax] <= dp_in[ax];
         end
      end
      if (stage_en[ST_E6]) begin
         clamp_e_ff[5] <= clamp_e_ff[4];
         for (int ax = 0; ax < NA; ax++) begin
            pixel_ff[ax] <= pixel_in[ax];
         end
      end
   end

   // Response word from the output register.
   assign rsp_chan.valid         = valid_ff[PS-1];
   assign rsp_chan.pixel_x       = pixel_ff[cbpe_pkg::AXIS_X];
   assign rsp_chan.pixel_y       = pixel_ff[cbpe_pkg::AXIS_Y];
   assign rsp_chan.index_clamped = clamp_e_ff[cbpe_pkg::EVAL_STAGES-1];

`ifndef ASSERT_OFF
   // An accepted word always lands in the entry stage.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("accepted word did not enter the pipeline");

   // A clamped index must give t equal to one.
   a_clamp_full: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && clamp_ff[0]) |-> div_q_ff[0][FB])
      else $error("clamped index without full parameter");

   // When t reaches one its fraction must be zero.
   a_t_max: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DS] && div_q_ff[DS][FB]) |-> (div_q_ff[DS][FB-1:0] == '0))
      else $error("parameter above one");

   // A full pipeline with a stalled receiver must refuse new words.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("word taken while pipeline is full and stalled");
`endif

endmodule

`default_nettype wire

/* sim/tb_cubic_bezier_point_evaluator.sv */
module tb_cubic_bezier_point_evaluator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_PERCENT    = 28;
   localparam int HOLD_CYCLES     = 90;
   localparam int DRAIN_CYCLES    = cbpe_pkg::PIPE_STAGES + 8;
   localparam int NUM_PHASES      = 8;
   localparam int WORDS_PER_PHASE = 212;
   localparam int HOLD_PHASE      = 1;
   localparam int NUM_ROWS        = 18;

   // One request word: four control points and the sample index.
   typedef struct packed {
      cbpe_pkg::coord_type p0_x;
      cbpe_pkg::coord_type p0_y;
      cbpe_pkg::coord_type p1_x;
      cbpe_pkg::coord_type p1_y;
      cbpe_pkg::coord_type p2_x;
      cbpe_pkg::coord_type p2_y;
      cbpe_pkg::coord_type p3_x;
      cbpe_pkg::coord_type p3_y;
      cbpe_pkg::index_type sample_index;
   } curve_req_type;

   // One response word.
   typedef struct packed {
      cbpe_pkg::coord_type pixel_x;
      cbpe_pkg::coord_type pixel_y;
      logic                index_clamped;
   } curve_point_type;

   // A directed row; when known is set the point is typed in, else it is predicted.
   typedef struct packed {
      curve_req_type   req;
      logic            known;
      curve_point_type want;
   } directed_row_type;

   // Directed rows, all run with the reset point count of 1000.
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b0}},
      '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 0},
        1'b1, '{-32768, 32767, 1'b0}},
      '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 1000},
        1'b1, '{32767, -32768, 1'b0}},
      '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 1001},
        1'b1, '{32767, -32768, 1'b1}},
      '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 65535},
        1'b1, '{32767, -32768, 1'b1}},
      '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 500},
        1'b0, '{0, 0, 1'b0}},
      '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 1},
        1'b0, '{0, 0, 1'b0}},
      '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 999},
        1'b0, '{0, 0, 1'b0}},
      '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 333},
        1'b1, '{-32768, -32768, 1'b0}},
      '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 777},
        1'b1, '{32767, 32767, 1'b0}},
      // Exact halves at t = 1/2: plus one half rounds up, minus one half to zero.
      '{'{4, -4, 0, 0, 0, 0, 0, 0, 500}, 1'b1, '{1, 0, 1'b0}},
      '{'{-12, 12, 0, 0, 0, 0, 0, 0, 500}, 1'b1, '{-1, 2, 1'b0}},
      '{'{0, 0, 8, -8, 0, 0, 0, 0, 500}, 1'b1, '{3, -3, 1'b0}},
      '{'{100, -100, 200, 0, -300, 50, 400, 7, 250}, 1'b0, '{0, 0, 1'b0}},
      '{'{1, 2, 3, 4, 5, 6, -1234, 4321, 21845}, 1'b1, '{-1234, 4321, 1'b1}},
      '{'{1, 2, 3, 4, 5, 6, -1234, 4321, 43690}, 1'b1, '{-1234, 4321, 1'b1}},
      '{'{21845, -21846, -21846, 21845, 21845, -21846, -21846, 21845, 999},
        1'b0, '{0, 0, 1'b0}},
      '{'{-1, 1, -2, 2, -3, 3, -4, 4, 123}, 1'b0, '{0, 0, 1'b0}}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   cbpe_pkg::index_type csr_wr_data;

   cbpe_req_if req_if ();
   cbpe_rsp_if rsp_if ();

   cubic_bezier_point_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Our copy of the point count register and the queue of points still owed.
   cbpe_pkg::index_type curve_steps;
   curve_point_type     points_due [$];
   int                  failures     = 0;
   bit                  steady       = 1'b0;
   int                  holds_asked  = 0;
   int                  holds_served = 0;
   int                  stall_left   = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Exact cubic at t (FRACTION_BITS fraction bits), rounded half up.
   function automatic cbpe_pkg::coord_type axis_round(
      cbpe_pkg::coord_type q0, cbpe_pkg::coord_type q1, cbpe_pkg::coord_type q2,
      cbpe_pkg::coord_type q3, cbpe_pkg::tval_type t);
      logic signed [95:0] w0, w1, w2, w3, tw, c0, c1, c2, total;
      w0 = q0;
      w1 = q1;
      w2 = q2;
      w3 = q3;
      tw = t;
      c0 = -w0 + 3 * w1 - 3 * w2 + w3;
      c1 = 3 * w0 - 6 * w1 + 3 * w2;
      c2 = 3 * (w1 - w0);
      // Everything is scaled by 2^(3 * FRACTION_BITS), so the sum stays exact.
      total = c0 * tw * tw * tw
            + ((c1 * tw * tw) <<< cbpe_pkg::FRACTION_BITS)
            + ((c2 * tw) <<< (2 * cbpe_pkg::FRACTION_BITS))
            + (w0 <<< (3 * cbpe_pkg::FRACTION_BITS))
            + (96'sd1 <<< (3 * cbpe_pkg::FRACTION_BITS - 1));
      total = total >>> (3 * cbpe_pkg::FRACTION_BITS);
      return total[cbpe_pkg::COORD_BITS-1:0];
   endfunction

   // Curve point for one request word under the given point count.
   function automatic curve_point_type bezier_point(curve_req_type w,
                                                    cbpe_pkg::index_type count);
      curve_point_type                                     p;
      logic [cbpe_pkg::INDEX_BITS:0]                       steps;
      logic [cbpe_pkg::INDEX_BITS:0]                       idx;
      logic [cbpe_pkg::INDEX_BITS+cbpe_pkg::FRACTION_BITS:0] scaled;
      cbpe_pkg::tval_type                                  t;
      steps = {1'b0, (count == '0) ? cbpe_pkg::index_type'(1) : count};
      p.index_clamped = ({1'b0, w.sample_index} > steps);
      idx = p.index_clamped ? steps : {1'b0, w.sample_index};
      scaled = {idx, {cbpe_pkg::FRACTION_BITS{1'b0}}};
      t = cbpe_pkg::tval_type'(scaled / steps);
      p.pixel_x = axis_round(w.p0_x, w.p1_x, w.p2_x, w.p3_x, t);
      p.pixel_y = axis_round(w.p0_y, w.p1_y, w.p2_y, w.p3_y, t);
      return p;
   endfunction

   function automatic cbpe_pkg::coord_type random_coord(int style);
      case (style)
         0:       return $urandom_range(1, 0) ? cbpe_pkg::coord_type'(32767)
                                              : cbpe_pkg::coord_type'(-32768);
         1, 2:    return cbpe_pkg::coord_type'(int'($urandom_range(128)) - 64);
         default: return cbpe_pkg::coord_type'($urandom);
      endcase
   endfunction

   // Random word: mostly in-range indices, with the ends and overruns mixed in.
   function automatic curve_req_type random_word(int unsigned steps);
      curve_req_type w;
      int            style;
      style = $urandom_range(9);
      w.p0_x = random_coord(style);
      w.p0_y = random_coord(style);
      w.p1_x = random_coord(style);
      w.p1_y = random_coord(style);
      w.p2_x = random_coord(style);
      w.p2_y = random_coord(style);
      w.p3_x = random_coord(style);
      w.p3_y = random_coord(style);
      case ($urandom_range(19))
         0:       w.sample_index = '0;
         1:       w.sample_index = cbpe_pkg::index_type'(steps);
         2:       w.sample_index = cbpe_pkg::index_type'(steps + 1);
         3:       w.sample_index = '1;
         4, 5:    w.sample_index = cbpe_pkg::index_type'($urandom);
         default: w.sample_index = cbpe_pkg::index_type'($urandom_range(steps, 0));
      endcase
      return w;
   endfunction

   task automatic drive_word(input curve_req_type w, input logic valid);
      req_if.valid        <= valid;
      req_if.p0_x         <= w.p0_x;
      req_if.p0_y         <= w.p0_y;
      req_if.p1_x         <= w.p1_x;
      req_if.p1_y         <= w.p1_y;
      req_if.p2_x         <= w.p2_x;
      req_if.p2_y         <= w.p2_y;
      req_if.p3_x         <= w.p3_x;
      req_if.p3_y         <= w.p3_y;
      req_if.sample_index <= w.sample_index;
   endtask

   // Offer one word, possibly after a random gap, and log the point it owes.
   task automatic send_word(input curve_req_type word, input curve_point_type want,
                            input logic known);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      drive_word(word, 1'b1);
      do @(posedge clock); while (!req_if.ready);
      points_due.push_back(known ? want : bezier_point(word, curve_steps));
   endtask

   // Drain the pipeline, then write the point count while nothing is in flight.
   task automatic write_point_count(input cbpe_pkg::index_type value);
      req_if.valid <= 1'b0;
      while (points_due.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      curve_steps = value;
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Compare an accepted response word with the oldest point owed.
   task automatic check_point();
      curve_point_type want;
      if (points_due.size() == 0) begin
         failures++;
         $display("%0t: response word with none expected, x=%0d y=%0d clamped=%0b",
                  $time, rsp_if.pixel_x, rsp_if.pixel_y, rsp_if.index_clamped);
      end else begin
         want = points_due.pop_front();
         if (rsp_if.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", want.pixel_x, rsp_if.pixel_x);
         if (rsp_if.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", want.pixel_y, rsp_if.pixel_y);
         if (rsp_if.index_clamped !== want.index_clamped)
            report_mismatch("index_clamped", want.index_clamped, rsp_if.index_clamped);
      end
   endtask

   // Receiver: checks every accepted word and stalls at random, with one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_point();
         if (stall_left == 0 && holds_served < holds_asked) begin
            holds_served++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Stimulus: directed rows, then random phases under several point counts.
   initial begin
      cbpe_pkg::index_type counts [NUM_PHASES];
      int unsigned         steps;
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      drive_word('0, 1'b0);
      curve_steps = cbpe_pkg::POINT_COUNT_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r])
         send_word(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].want, DIRECTED_ROWS[r].known);

      // Zero acts as one; the long hold-off runs in a phase with no sender gaps.
      counts = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd1000, 16'd3, 16'd1001, 16'd7};
      counts[5] = cbpe_pkg::index_type'($urandom_range(999, 3));
      counts[6] = cbpe_pkg::index_type'($urandom_range(65534, 1001));
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_point_count(counts[ph]);
         steady = (ph == HOLD_PHASE);
         if (ph == HOLD_PHASE)
            holds_asked++;
         steps = (curve_steps == '0) ? 1 : curve_steps;
         repeat (WORDS_PER_PHASE)
            send_word(random_word(steps), '0, 1'b0);
      end

      steady = 1'b0;
      req_if.valid <= 1'b0;
      while (points_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
